### sv/pve_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pve_pkg
// Shared types, constants and helper functions for the pose velocity
// estimator: controller commands, status and quaternion product ordering.
// ----------------------------------------------------------------------------
package pve_pkg;

    localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
    localparam logic [31:0] TWO_NS     = 32'd2000000000;
    localparam int ANG_SHIFT = 12;

    localparam logic [1:0] SRC_FIRST = 2'd0;
    localparam logic [1:0] SRC_CALC  = 2'd1;
    localparam logic [1:0] SRC_HELD  = 2'd2;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DT_LO,
        MUL_DT_HI,
        MUL_D_LO,
        MUL_D_HI,
        MUL_QP,
        MUL_S_LO,
        MUL_S_HI
    } mul_sel_t;

    typedef enum logic [1:0] {
        VEL_KEEP,
        VEL_ZERO,
        VEL_HOLD,
        VEL_STORE
    } vel_op_t;

    typedef struct packed {
        mul_sel_t   mul_sel;
        logic [1:0] axis;
        logic [1:0] term;
        logic       acc_clr;
        logic       acc_init_nd;
        logic       s_load;
        logic       dt_load;
        logic       div_init;
        logic       div_step;
        logic       ang;
        vel_op_t    vel_op;
        logic [2:0] vel_idx;
        logic       src_load;
        logic [1:0] src;
        logic       commit;
    } cmd_t;

    typedef struct packed {
        logic have_prev;
        logic dt_pos;
    } sts_t;

    // current quaternion component paired with previous component term
    function automatic logic [1:0] q_sel(input logic [1:0] axis, input logic [1:0] term);
        return term ^ (axis + 2'd1);
    endfunction

    function automatic logic term_neg(input logic [1:0] axis, input logic [1:0] term);
        logic neg;
        case (axis)
            2'd0:    neg = (term == 2'd1) || (term == 2'd2);
            2'd1:    neg = (term == 2'd2) || (term == 2'd3);
            default: neg = (term == 2'd1) || (term == 2'd3);
        endcase
        return neg;
    endfunction

endpackage
`default_nettype wire

### sv/pve_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pve_datapath
// Pose registers, shared signed multiplier with accumulator, restoring
// divider and velocity saturation, driven by controller commands.
// ----------------------------------------------------------------------------
module pve_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_load,
    input  wire logic [31:0]         stamp_sec,
    input  wire logic [29:0]         stamp_nsec,
    input  wire logic signed [31:0]  pos_x,
    input  wire logic signed [31:0]  pos_y,
    input  wire logic signed [31:0]  pos_z,
    input  wire logic signed [15:0]  quat_w,
    input  wire logic signed [15:0]  quat_x,
    input  wire logic signed [15:0]  quat_y,
    input  wire logic signed [15:0]  quat_z,
    input  wire pve_pkg::cmd_t       cmd,
    output pve_pkg::sts_t            sts,
    output logic signed [31:0]       lin_vel_x,
    output logic signed [31:0]       lin_vel_y,
    output logic signed [31:0]       lin_vel_z,
    output logic signed [31:0]       ang_vel_x,
    output logic signed [31:0]       ang_vel_y,
    output logic signed [31:0]       ang_vel_z,
    output logic [1:0]               vel_source
);

    logic [31:0]        in_sec_reg;
    logic [29:0]        in_nsec_reg;
    logic signed [31:0] in_pos_reg [3];
    logic signed [15:0] in_quat_reg [4];

    logic               have_prev_reg;
    logic [31:0]        prev_sec_reg;
    logic [29:0]        prev_nsec_reg;
    logic signed [31:0] prev_pos_reg [3];
    logic signed [15:0] prev_quat_reg [4];
    logic signed [31:0] prev_vel_reg [6];

    logic signed [31:0] vel_reg [6];
    logic signed [31:0] out_vel_reg [6];
    logic [1:0]         src_reg;
    logic [1:0]         out_src_reg;

    logic signed [49:0] prod_reg;
    logic               add_pend_reg;
    logic               sub_pend_reg;
    logic               sh_pend_reg;
    logic signed [63:0] acc_reg;
    logic signed [33:0] s_reg;
    logic [62:0]        dt_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        quo_reg;
    logic               neg_reg;

    logic signed [32:0] sd;
    logic signed [30:0] nd;
    logic signed [32:0] dpos;
    logic signed [31:0] pos_cur;
    logic signed [31:0] pos_prv;
    logic signed [15:0] p_op;
    logic signed [15:0] q_op;
    logic signed [17:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [49:0] prod_next;
    logic signed [63:0] prod_ext;
    logic signed [63:0] addend;
    logic signed [63:0] acc_next;
    logic [63:0]        rem_sh;
    logic [64:0]        diff;
    logic [63:0]        qv;
    logic signed [31:0] sat_val;

    assign sd = $signed({1'b0, in_sec_reg}) - $signed({1'b0, prev_sec_reg});
    assign nd = $signed({1'b0, in_nsec_reg}) - $signed({1'b0, prev_nsec_reg});

    always_comb
    begin
        case (cmd.axis)
            2'd0:
            begin
                pos_cur = in_pos_reg[0];
                pos_prv = prev_pos_reg[0];
            end
            2'd1:
            begin
                pos_cur = in_pos_reg[1];
                pos_prv = prev_pos_reg[1];
            end
            default:
            begin
                pos_cur = in_pos_reg[2];
                pos_prv = prev_pos_reg[2];
            end
        endcase
    end

    assign dpos = 33'(pos_cur) - 33'(pos_prv);
    assign p_op = prev_quat_reg[cmd.term];
    assign q_op = in_quat_reg[pve_pkg::q_sel(cmd.axis, cmd.term)];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            pve_pkg::MUL_DT_LO:
            begin
                mul_a = {2'b00, sd[15:0]};
                mul_b = pve_pkg::NS_PER_SEC;
            end
            pve_pkg::MUL_DT_HI:
            begin
                mul_a = {sd[32], sd[32:16]};
                mul_b = pve_pkg::NS_PER_SEC;
            end
            pve_pkg::MUL_D_LO:
            begin
                mul_a = {2'b00, dpos[15:0]};
                mul_b = pve_pkg::NS_PER_SEC;
            end
            pve_pkg::MUL_D_HI:
            begin
                mul_a = {dpos[32], dpos[32:16]};
                mul_b = pve_pkg::NS_PER_SEC;
            end
            pve_pkg::MUL_QP:
            begin
                mul_a = {{2{p_op[15]}}, p_op};
                mul_b = {{16{q_op[15]}}, q_op};
            end
            pve_pkg::MUL_S_LO:
            begin
                mul_a = {2'b00, s_reg[15:0]};
                mul_b = pve_pkg::TWO_NS;
            end
            pve_pkg::MUL_S_HI:
            begin
                mul_a = s_reg[33:16];
                mul_b = pve_pkg::TWO_NS;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = {{14{prod_reg[49]}}, prod_reg};
    assign addend    = sh_pend_reg ? {prod_ext[47:0], 16'd0} : prod_ext;

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clr)
            acc_next = cmd.acc_init_nd ? 64'(nd) : 64'sd0;
        else if (add_pend_reg)
            acc_next = sub_pend_reg ? acc_reg - addend : acc_reg + addend;
    end

    // restoring division, one quotient bit per step
    assign rem_sh = {rem_reg[62:0], quo_reg[63]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dt_reg};

    assign qv = cmd.ang ? (quo_reg >> pve_pkg::ANG_SHIFT) : quo_reg;

    always_comb
    begin
        if (|qv[63:31])
            sat_val = neg_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else if (neg_reg)
            sat_val = -$signed(qv[31:0]);
        else
            sat_val = $signed(qv[31:0]);
    end

    assign sts.have_prev = have_prev_reg;
    assign sts.dt_pos    = !acc_reg[63] && (acc_reg != 64'sd0);

    // captured pose and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_sec_reg     <= stamp_sec;
            in_nsec_reg    <= stamp_nsec;
            in_pos_reg[0]  <= pos_x;
            in_pos_reg[1]  <= pos_y;
            in_pos_reg[2]  <= pos_z;
            in_quat_reg[0] <= quat_w;
            in_quat_reg[1] <= quat_x;
            in_quat_reg[2] <= quat_y;
            in_quat_reg[3] <= quat_z;
        end
        prod_reg <= prod_next;
        sub_pend_reg <= (cmd.mul_sel == pve_pkg::MUL_QP) &&
                        pve_pkg::term_neg(cmd.axis, cmd.term);
        sh_pend_reg <= (cmd.mul_sel == pve_pkg::MUL_DT_HI) ||
                       (cmd.mul_sel == pve_pkg::MUL_D_HI) ||
                       (cmd.mul_sel == pve_pkg::MUL_S_HI);
        acc_reg <= acc_next;
        if (cmd.s_load)
            s_reg <= acc_reg[33:0];
        if (cmd.dt_load)
            dt_reg <= acc_reg[62:0];
        if (cmd.div_init)
        begin
            neg_reg <= acc_reg[63];
            quo_reg <= acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!diff[64])
            begin
                rem_reg <= diff[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        case (cmd.vel_op)
            pve_pkg::VEL_ZERO:
                for (int i = 0; i < 6; i++)
                    vel_reg[i] <= '0;
            pve_pkg::VEL_HOLD:
                for (int i = 0; i < 6; i++)
                    vel_reg[i] <= prev_vel_reg[i];
            pve_pkg::VEL_STORE:
                for (int i = 0; i < 6; i++)
                    if (cmd.vel_idx == 3'(i))
                        vel_reg[i] <= sat_val;
            default:
            begin
            end
        endcase
        if (cmd.src_load)
            src_reg <= cmd.src;
        if (cmd.commit)
        begin
            for (int i = 0; i < 6; i++)
                out_vel_reg[i] <= vel_reg[i];
            out_src_reg <= src_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            add_pend_reg <= 1'b0;
        else
            add_pend_reg <= (cmd.mul_sel != pve_pkg::MUL_NONE);
    end

    // previous pose state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_sec_reg  <= '0;
            prev_nsec_reg <= '0;
            for (int i = 0; i < 3; i++)
                prev_pos_reg[i] <= '0;
            for (int i = 0; i < 4; i++)
                prev_quat_reg[i] <= '0;
            for (int i = 0; i < 6; i++)
                prev_vel_reg[i] <= '0;
        end
        else if (cmd.commit)
        begin
            have_prev_reg <= 1'b1;
            prev_sec_reg  <= in_sec_reg;
            prev_nsec_reg <= in_nsec_reg;
            for (int i = 0; i < 3; i++)
                prev_pos_reg[i] <= in_pos_reg[i];
            for (int i = 0; i < 4; i++)
                prev_quat_reg[i] <= in_quat_reg[i];
            for (int i = 0; i < 6; i++)
                prev_vel_reg[i] <= vel_reg[i];
        end
    end

    assign lin_vel_x  = out_vel_reg[0];
    assign lin_vel_y  = out_vel_reg[1];
    assign lin_vel_z  = out_vel_reg[2];
    assign ang_vel_x  = out_vel_reg[3];
    assign ang_vel_y  = out_vel_reg[4];
    assign ang_vel_z  = out_vel_reg[5];
    assign vel_source = out_src_reg;

endmodule
`default_nettype wire

### sv/pve_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pve_ctrl
// Sequencer for one pose item: time step, six numerators, six divisions,
// then hand-off to the output register.
// ----------------------------------------------------------------------------
module pve_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               in_load,
    output pve_pkg::cmd_t      cmd,
    input  wire pve_pkg::sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_DT,
        S_CHK,
        S_NUM,
        S_SCL,
        S_DIVI,
        S_DIV,
        S_STORE,
        S_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [2:0] ch_reg, ch_next;
    logic       out_valid_reg;
    logic       ang;

    assign ang      = (ch_reg >= 3'd3);
    assign in_ready = (state_reg == S_IDLE);
    assign in_load  = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        cmd = '0;
        cmd.mul_sel = pve_pkg::MUL_NONE;
        cmd.vel_op  = pve_pkg::VEL_KEEP;
        cmd.axis    = ang ? 2'(ch_reg - 3'd3) : ch_reg[1:0];
        cmd.ang     = ang;
        cmd.vel_idx = ch_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_START;
            S_START:
            begin
                if (!sts.have_prev)
                begin
                    cmd.vel_op   = pve_pkg::VEL_ZERO;
                    cmd.src_load = 1'b1;
                    cmd.src      = pve_pkg::SRC_FIRST;
                    state_next   = S_FIN;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_DT;
                end
            end
            S_DT:
            begin
                cmd.acc_clr     = (cnt_reg == 6'd0);
                cmd.acc_init_nd = 1'b1;
                if (cnt_reg == 6'd0)
                    cmd.mul_sel = pve_pkg::MUL_DT_LO;
                else if (cnt_reg == 6'd1)
                    cmd.mul_sel = pve_pkg::MUL_DT_HI;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd2)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sts.dt_pos)
                begin
                    cmd.dt_load = 1'b1;
                    ch_next     = '0;
                    cnt_next    = '0;
                    state_next  = S_NUM;
                end
                else
                begin
                    cmd.vel_op   = pve_pkg::VEL_HOLD;
                    cmd.src_load = 1'b1;
                    cmd.src      = pve_pkg::SRC_HELD;
                    state_next   = S_FIN;
                end
            end
            S_NUM:
            begin
                cmd.acc_clr = (cnt_reg == 6'd0);
                cnt_next    = cnt_reg + 6'd1;
                if (!ang)
                begin
                    if (cnt_reg == 6'd0)
                        cmd.mul_sel = pve_pkg::MUL_D_LO;
                    else if (cnt_reg == 6'd1)
                        cmd.mul_sel = pve_pkg::MUL_D_HI;
                    if (cnt_reg == 6'd2)
                        state_next = S_DIVI;
                end
                else
                begin
                    // four products of the quaternion difference term
                    cmd.term = cnt_reg[1:0];
                    if (cnt_reg < 6'd4)
                        cmd.mul_sel = pve_pkg::MUL_QP;
                    else
                    begin
                        cnt_next   = '0;
                        state_next = S_SCL;
                    end
                end
            end
            S_SCL:
            begin
                cmd.s_load  = (cnt_reg == 6'd0);
                cmd.acc_clr = (cnt_reg == 6'd0);
                if (cnt_reg == 6'd1)
                    cmd.mul_sel = pve_pkg::MUL_S_LO;
                else if (cnt_reg == 6'd2)
                    cmd.mul_sel = pve_pkg::MUL_S_HI;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3)
                    state_next = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.vel_op = pve_pkg::VEL_STORE;
                cnt_next   = '0;
                if (ch_reg == 3'd5)
                begin
                    cmd.src_load = 1'b1;
                    cmd.src      = pve_pkg::SRC_CALC;
                    state_next   = S_FIN;
                end
                else
                begin
                    ch_next    = ch_reg + 3'd1;
                    state_next = S_NUM;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ch_reg    <= ch_next;
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

### sv/pose_velocity_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pose_velocity_estimator
// Finite difference linear and angular velocity from timestamped poses.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    stamp_sec, stamp_nsec, pos_x..z, quat_w..z
//  out      out_valid/out_ready  lin_vel_x..z, ang_vel_x..z, vel_source
//
//  a first sample or a non-positive time step skips the divisions; a computed
//  item runs six 64-step restoring divisions on one shared divider plus the
//  multiply steps on one shared multiplier.
//  reset clears the previous pose, previous velocities and the first-sample flag.
//  a finished result waits in the output register while the next item is taken;
//  a second result waits in the final state until the output register frees.
// ----------------------------------------------------------------------------
module pose_velocity_estimator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [31:0]        stamp_sec,
    input  wire logic [29:0]        stamp_nsec,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [15:0] quat_w,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      lin_vel_x,
    output logic signed [31:0]      lin_vel_y,
    output logic signed [31:0]      lin_vel_z,
    output logic signed [31:0]      ang_vel_x,
    output logic signed [31:0]      ang_vel_y,
    output logic signed [31:0]      ang_vel_z,
    output logic [1:0]              vel_source
);

    pve_pkg::cmd_t cmd;
    pve_pkg::sts_t sts;
    logic          in_load;

    pve_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .in_load   (in_load),
        .cmd       (cmd),
        .sts       (sts)
    );

    pve_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_load    (in_load),
        .stamp_sec  (stamp_sec),
        .stamp_nsec (stamp_nsec),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .quat_w     (quat_w),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .cmd        (cmd),
        .sts        (sts),
        .lin_vel_x  (lin_vel_x),
        .lin_vel_y  (lin_vel_y),
        .lin_vel_z  (lin_vel_z),
        .ang_vel_x  (ang_vel_x),
        .ang_vel_y  (ang_vel_y),
        .ang_vel_z  (ang_vel_z),
        .vel_source (vel_source)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block took a second item while busy");

    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (vel_source == pve_pkg::SRC_FIRST) |->
        (lin_vel_x == 0) && (lin_vel_y == 0) && (lin_vel_z == 0) &&
        (ang_vel_x == 0) && (ang_vel_y == 0) && (ang_vel_z == 0))
        else $error("first sample result carries nonzero velocity");

    a_src_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (vel_source == pve_pkg::SRC_FIRST) ||
        (vel_source == pve_pkg::SRC_CALC) || (vel_source == pve_pkg::SRC_HELD))
        else $error("result source code out of range");

    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !out_valid || out_ready)
        else $error("result overwrote an untaken item");
`endif

endmodule
`default_nettype wire
